FILE: sv/dtfp_pkg.sv
`timescale 1ns / 1ps

package dtfp_pkg;

  localparam int DEFAULT_VALUE_BITS          = 32;
  localparam int DEFAULT_MAX_FRACTION_DIGITS = 9;
  localparam int ACC_W                       = 30;
  localparam int CFG_IDX_W                   = 3;
  localparam int CFG_DATA_W                  = 5;

  localparam logic [3:0] INT_DIGIT_CAP = 4'd9;

  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [2:0] ST_OK             = 3'd0;
  localparam logic [2:0] ST_TOO_LONG       = 3'd1;
  localparam logic [2:0] ST_INT_DIGITS     = 3'd2;
  localparam logic [2:0] ST_FRAC_DIGITS    = 3'd3;
  localparam logic [2:0] ST_BAD_CHAR       = 3'd4;
  localparam logic [2:0] ST_INT_RANGE      = 3'd5;
  localparam logic [2:0] ST_POS_FRAC_RANGE = 3'd6;
  localparam logic [2:0] ST_NEG_FRAC_RANGE = 3'd7;

  localparam logic [CFG_IDX_W-1:0] CFG_FRACTION_BITS       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEGER_BITS        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_INTEGER_DIGITS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRACTION_DIGITS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH          = 3'd4;

  localparam logic [4:0] FRACTION_BITS_RST       = 5'd15;
  localparam logic [4:0] INTEGER_BITS_RST        = 5'd16;
  localparam logic [3:0] MAX_INTEGER_DIGITS_RST  = 4'd5;
  localparam logic [3:0] MAX_FRACTION_DIGITS_RST = 4'd6;
  localparam logic [4:0] MAX_LENGTH_RST          = 5'd13;

  typedef enum logic [1:0] {
    PH_SIGN = 2'd0,
    PH_INT  = 2'd1,
    PH_FRAC = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    CV_IDLE  = 2'd0,
    CV_CHECK = 2'd1,
    CV_STEP  = 2'd2,
    CV_DONE  = 2'd3
  } conv_state_t;

  typedef struct packed {
    logic [7:0] text_char;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] fixed_value;
    logic [2:0]         status;
  } out_item_t;

  typedef struct packed {
    logic             negative;
    logic [ACC_W-1:0] int_accum;
    logic [ACC_W-1:0] frac_accum;
    logic [3:0]       frac_count;
    logic [2:0]       err;
  } number_t;

  function automatic logic [ACC_W-1:0] pow10(input logic [3:0] n);
    logic [ACC_W-1:0] p;
    case (n)
      4'd0:    p = 30'd1;
      4'd1:    p = 30'd10;
      4'd2:    p = 30'd100;
      4'd3:    p = 30'd1000;
      4'd4:    p = 30'd10000;
      4'd5:    p = 30'd100000;
      4'd6:    p = 30'd1000000;
      4'd7:    p = 30'd10000000;
      4'd8:    p = 30'd100000000;
      default: p = 30'd1000000000;
    endcase
    return p;
  endfunction

endpackage

FILE: sv/dtfp_conv.sv
`timescale 1ns / 1ps

module dtfp_conv import dtfp_pkg::*; #(
  parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  number_t    num,
  input  logic [4:0] fraction_bits,
  input  logic [4:0] integer_bits,
  input  logic       out_free,
  output logic       busy,
  output logic       done,
  output out_item_t  result
);

  localparam logic [4:0] FB_MAX = 5'(VALUE_BITS - 1);

  conv_state_t state_r, state_nxt;
  number_t     num_r, num_nxt;
  logic [VALUE_BITS-1:0] acc_r, acc_nxt;
  logic [ACC_W:0]        rem_r, rem_nxt;
  logic [ACC_W-1:0]      scale_r, scale_nxt;
  logic [4:0]            cnt_r, cnt_nxt;
  logic [2:0]            status_r, status_nxt;

  logic [4:0]  fb, ib_room, ib;
  logic [31:0] lim, lim_m1, iv;
  logic        frac_nz;
  logic [2:0]  chk_status;
  logic [ACC_W:0] rem_dbl, scale_ext;
  logic        ge;
  logic [VALUE_BITS-1:0] res_val;

  assign fb      = (fraction_bits > FB_MAX) ? FB_MAX : fraction_bits;
  assign ib_room = FB_MAX - fb;
  assign ib      = (integer_bits > ib_room) ? ib_room : integer_bits;
  assign lim     = 32'd1 << ib;
  assign lim_m1  = lim - 32'd1;
  assign iv      = 32'(num_r.int_accum);
  assign frac_nz = (num_r.frac_accum != '0);

  always_comb begin
    chk_status = num_r.err;
    if (num_r.err == ST_OK) begin
      if ((num_r.negative && iv > lim) || (!num_r.negative && iv > lim_m1)) begin
        chk_status = ST_INT_RANGE;
      end else if (!num_r.negative && iv == lim_m1 && frac_nz) begin
        chk_status = ST_POS_FRAC_RANGE;
      end else if (num_r.negative && iv == lim && frac_nz) begin
        chk_status = ST_NEG_FRAC_RANGE;
      end
    end
  end

  // one restoring step per fraction bit
  assign rem_dbl   = {rem_r[ACC_W-1:0], 1'b0};
  assign scale_ext = {1'b0, scale_r};
  assign ge        = (rem_dbl >= scale_ext);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CV_IDLE: begin
        if (start) state_nxt = CV_CHECK;
      end
      CV_CHECK: begin
        if (chk_status != ST_OK || fb == 5'd0) state_nxt = CV_DONE;
        else state_nxt = CV_STEP;
      end
      CV_STEP: begin
        if (cnt_r == 5'd1) state_nxt = CV_DONE;
      end
      CV_DONE: begin
        if (out_free) state_nxt = CV_IDLE;
      end
      default: state_nxt = CV_IDLE;
    endcase
  end

  always_comb begin
    num_nxt    = num_r;
    acc_nxt    = acc_r;
    rem_nxt    = rem_r;
    scale_nxt  = scale_r;
    cnt_nxt    = cnt_r;
    status_nxt = status_r;
    unique case (state_r)
      CV_IDLE: begin
        if (start) num_nxt = num;
      end
      CV_CHECK: begin
        status_nxt = chk_status;
        acc_nxt    = VALUE_BITS'(num_r.int_accum);
        rem_nxt    = {1'b0, num_r.frac_accum};
        scale_nxt  = pow10(num_r.frac_count);
        cnt_nxt    = fb;
      end
      CV_STEP: begin
        rem_nxt = ge ? (rem_dbl - scale_ext) : rem_dbl;
        acc_nxt = {acc_r[VALUE_BITS-2:0], ge};
        cnt_nxt = cnt_r - 5'd1;
      end
      default: begin
      end
    endcase
  end

  assign res_val = num_r.negative ? (~acc_r + VALUE_BITS'(1)) : acc_r;

  always_comb begin
    busy = (state_r != CV_IDLE);
    done = (state_r == CV_DONE) && out_free;
    result.status      = status_r;
    result.fixed_value = (status_r != ST_OK) ? 32'sd0 : 32'($signed(res_val));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    num_r    <= num_nxt;
    acc_r    <= acc_nxt;
    rem_r    <= rem_nxt;
    scale_r  <= scale_nxt;
    cnt_r    <= cnt_nxt;
    status_r <= status_nxt;
  end

endmodule

FILE: sv/decimal_text_to_fixed_point.sv
`timescale 1ns / 1ps
// Characters are parsed one per cycle; in_stall stays low while a number is read.
// After the last item the converter runs a check state, one step per fraction bit
// (fraction_bits clamped to VALUE_BITS-1, no steps on an error status) and a hand-off
// state that waits until the output register is free before out_valid rises.
// in_stall is high through all of those states, so no new number is taken meanwhile.
// Synchronous active-low reset clears the parser, returns the converter to idle and clears out_valid.
module decimal_text_to_fixed_point import dtfp_pkg::*; #(
  parameter int VALUE_BITS          = DEFAULT_VALUE_BITS,
  parameter int MAX_FRACTION_DIGITS = DEFAULT_MAX_FRACTION_DIGITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic [3:0] FRAC_CAP = 4'(MAX_FRACTION_DIGITS);

  logic [4:0] fraction_bits_r, integer_bits_r, max_length_r;
  logic [3:0] max_int_digits_r, max_frac_digits_r;

  phase_t           phase_r, phase_nxt;
  logic             neg_r, neg_nxt;
  logic [ACC_W-1:0] int_acc_r, int_acc_nxt;
  logic [ACC_W-1:0] frac_acc_r, frac_acc_nxt;
  logic [3:0]       int_cnt_r, int_cnt_nxt;
  logic [3:0]       frac_cnt_r, frac_cnt_nxt;
  logic [4:0]       char_cnt_r, char_cnt_nxt;
  logic [2:0]       err_r, err_nxt;

  logic             out_valid_r;
  out_item_t        out_item_r;

  logic             in_acc, is_digit, sign_char;
  logic [7:0]       ch, ch_off;
  logic [ACC_W-1:0] dval;
  logic [3:0]       ilim, flim;
  logic             conv_busy, conv_done, out_free;
  number_t          num;
  out_item_t        conv_result;

  assign in_acc    = in_valid && !in_stall;
  assign ch        = in_item.text_char;
  assign ch_off    = ch - CH_ZERO;
  assign dval      = ACC_W'(ch_off[3:0]);
  assign is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign sign_char = (ch == CH_PLUS) || (ch == CH_MINUS);
  assign ilim      = (max_int_digits_r > INT_DIGIT_CAP) ? INT_DIGIT_CAP : max_int_digits_r;
  assign flim      = (max_frac_digits_r > FRAC_CAP) ? FRAC_CAP : max_frac_digits_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fraction_bits_r   <= FRACTION_BITS_RST;
      integer_bits_r    <= INTEGER_BITS_RST;
      max_int_digits_r  <= MAX_INTEGER_DIGITS_RST;
      max_frac_digits_r <= MAX_FRACTION_DIGITS_RST;
      max_length_r      <= MAX_LENGTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRACTION_BITS:       fraction_bits_r   <= cfg_wdata;
        CFG_INTEGER_BITS:        integer_bits_r    <= cfg_wdata;
        CFG_MAX_INTEGER_DIGITS:  max_int_digits_r  <= cfg_wdata[3:0];
        CFG_MAX_FRACTION_DIGITS: max_frac_digits_r <= cfg_wdata[3:0];
        CFG_MAX_LENGTH:          max_length_r      <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    neg_nxt      = neg_r;
    int_acc_nxt  = int_acc_r;
    frac_acc_nxt = frac_acc_r;
    int_cnt_nxt  = int_cnt_r;
    frac_cnt_nxt = frac_cnt_r;
    char_cnt_nxt = char_cnt_r;
    err_nxt      = err_r;
    if (in_acc) begin
      // too long overrides any earlier error
      if (char_cnt_r >= max_length_r) err_nxt = ST_TOO_LONG;
      if (char_cnt_r != 5'd31) char_cnt_nxt = char_cnt_r + 5'd1;
      if (phase_r == PH_SIGN) phase_nxt = PH_INT;
      if (phase_r == PH_SIGN && sign_char) begin
        neg_nxt = (ch == CH_MINUS);
      end else if (phase_r != PH_FRAC) begin
        if (ch == CH_POINT) begin
          phase_nxt = PH_FRAC;
        end else if (int_cnt_r >= ilim) begin
          if (err_nxt == ST_OK) err_nxt = ST_INT_DIGITS;
        end else begin
          int_cnt_nxt = int_cnt_r + 4'd1;
          if (!is_digit) begin
            if (err_nxt == ST_OK) err_nxt = ST_BAD_CHAR;
          end else begin
            int_acc_nxt = (int_acc_r << 3) + (int_acc_r << 1) + dval;
          end
        end
      end else begin
        if (frac_cnt_r >= flim) begin
          if (err_nxt == ST_OK) err_nxt = ST_FRAC_DIGITS;
        end else begin
          frac_cnt_nxt = frac_cnt_r + 4'd1;
          if (!is_digit) begin
            if (err_nxt == ST_OK) err_nxt = ST_BAD_CHAR;
          end else begin
            frac_acc_nxt = (frac_acc_r << 3) + (frac_acc_r << 1) + dval;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (in_acc && in_item.last_char)) begin
      phase_r    <= PH_SIGN;
      neg_r      <= 1'b0;
      int_acc_r  <= '0;
      frac_acc_r <= '0;
      int_cnt_r  <= '0;
      frac_cnt_r <= '0;
      char_cnt_r <= '0;
      err_r      <= ST_OK;
    end else begin
      phase_r    <= phase_nxt;
      neg_r      <= neg_nxt;
      int_acc_r  <= int_acc_nxt;
      frac_acc_r <= frac_acc_nxt;
      int_cnt_r  <= int_cnt_nxt;
      frac_cnt_r <= frac_cnt_nxt;
      char_cnt_r <= char_cnt_nxt;
      err_r      <= err_nxt;
    end
  end

  assign num.negative   = neg_nxt;
  assign num.int_accum  = int_acc_nxt;
  assign num.frac_accum = frac_acc_nxt;
  assign num.frac_count = frac_cnt_nxt;
  assign num.err        = err_nxt;

  assign out_free = !out_valid_r || !out_stall;

  dtfp_conv #(
    .VALUE_BITS(VALUE_BITS)
  ) u_conv (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (in_acc && in_item.last_char),
    .num           (num),
    .fraction_bits (fraction_bits_r),
    .integer_bits  (integer_bits_r),
    .out_free      (out_free),
    .busy          (conv_busy),
    .done          (conv_done),
    .result        (conv_result)
  );

  assign in_stall = conv_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (conv_done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (conv_done) out_item_r <= conv_result;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
